/* hdl/cbf_pkg.sv */
package cbf_pkg;

  localparam logic [31:0] MIX_C1 = 32'hcc9e2d51;
  localparam logic [31:0] MIX_C2 = 32'h1b873593;
  localparam logic [31:0] MIX_N  = 32'he6546b64;
  localparam logic [31:0] FMIX_1 = 32'h85ebca6b;
  localparam logic [31:0] FMIX_2 = 32'hc2b2ae35;

  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 32;
  localparam int SIZE_BITS     = 11;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_TABLE_SIZE = 2'd0,
    REG_SEED_A     = 2'd1,
    REG_SEED_B     = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_CHECK  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  // Hash/mix micro-operations, one multiply per cycle.
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD_SEED,
    OP_SCR_MUL1,
    OP_SCR_MUL2,
    OP_ABS_XOR,
    OP_ABS_MUL5,
    OP_TAIL_XOR,
    OP_FIN_LEN,
    OP_FIN_MUL1,
    OP_FIN_MUL2,
    OP_FIN_LAST
  } hop_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_BLK_M1,
    S_BLK_M2,
    S_BLK_XOR,
    S_BLK_M5,
    S_TL_M1,
    S_TL_M2,
    S_TL_XOR,
    S_FIN_LEN,
    S_FIN_M1,
    S_FIN_M2,
    S_FIN_LAST,
    S_MOD,
    S_RD_A,
    S_RD_B,
    S_WAIT_B,
    S_WR_A,
    S_RD_B2,
    S_WAIT_B2,
    S_WR_B,
    S_OUT
  } state_t;

  typedef struct packed {
    hop_t hop;
    logic tail_sel;
    logic mod_start;
    logic rd_a;
    logic rd_b;
    logic cap_a;
    logic cap_b;
    logic wr_a;
    logic wr_b;
    logic out_load;
    logic key_clear;
  } ctl_t;

  typedef struct packed {
    logic mod_done;
  } sts_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int r);
    rotl = (x << r) | (x >> (32 - r));
  endfunction

endpackage

/* hdl/cbf_stream_if.sv */
interface cbf_stream_if #(parameter int W = 8);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hdl/cbf_ram.sv */
module cbf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* hdl/cbf_ctrl.sv */
module cbf_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             blk_full,
  input  logic             is_last,
  input  logic             has_tail,
  input  logic [1:0]       cmd,
  input  logic             clearing,
  input  logic             out_busy,
  input  cbf_pkg::sts_t    sts,
  output cbf_pkg::ctl_t    ctl
);
  cbf_pkg::state_t state, state_next;
  logic acc;

  assign in_ready = (state == cbf_pkg::S_IDLE) && !clearing;
  assign acc = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cbf_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      cbf_pkg::S_IDLE: begin
        if (acc) begin
          if (blk_full) begin
            state_next = cbf_pkg::S_BLK_M1;
          end else if (is_last) begin
            state_next = has_tail ? cbf_pkg::S_TL_M1 : cbf_pkg::S_FIN_LEN;
          end
        end
      end
      cbf_pkg::S_BLK_M1:  state_next = cbf_pkg::S_BLK_M2;
      cbf_pkg::S_BLK_M2:  state_next = cbf_pkg::S_BLK_XOR;
      cbf_pkg::S_BLK_XOR: state_next = cbf_pkg::S_BLK_M5;
      cbf_pkg::S_BLK_M5:  state_next = is_last ? cbf_pkg::S_FIN_LEN : cbf_pkg::S_IDLE;
      cbf_pkg::S_TL_M1:   state_next = cbf_pkg::S_TL_M2;
      cbf_pkg::S_TL_M2:   state_next = cbf_pkg::S_TL_XOR;
      cbf_pkg::S_TL_XOR:  state_next = cbf_pkg::S_FIN_LEN;
      cbf_pkg::S_FIN_LEN: state_next = cbf_pkg::S_FIN_M1;
      cbf_pkg::S_FIN_M1:  state_next = cbf_pkg::S_FIN_M2;
      cbf_pkg::S_FIN_M2:  state_next = cbf_pkg::S_FIN_LAST;
      cbf_pkg::S_FIN_LAST:
        state_next = (cmd == cbf_pkg::CMD_NONE) ? cbf_pkg::S_IDLE : cbf_pkg::S_MOD;
      cbf_pkg::S_MOD:     if (sts.mod_done) state_next = cbf_pkg::S_RD_A;
      cbf_pkg::S_RD_A:    state_next = cbf_pkg::S_RD_B;
      cbf_pkg::S_RD_B:    state_next = cbf_pkg::S_WAIT_B;
      cbf_pkg::S_WAIT_B:  state_next = cbf_pkg::S_WR_A;
      cbf_pkg::S_WR_A:    state_next = cbf_pkg::S_RD_B2;
      cbf_pkg::S_RD_B2:   state_next = cbf_pkg::S_WAIT_B2;
      cbf_pkg::S_WAIT_B2: state_next = cbf_pkg::S_WR_B;
      cbf_pkg::S_WR_B:    state_next = cbf_pkg::S_OUT;
      cbf_pkg::S_OUT:     if (!out_busy) state_next = cbf_pkg::S_IDLE;
      default:            state_next = cbf_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    ctl.hop = cbf_pkg::OP_NOP;
    unique case (state)
      cbf_pkg::S_IDLE: begin
        if (acc && !blk_full && is_last) begin
          ctl.hop = cbf_pkg::OP_LOAD_SEED;
        end
      end
      cbf_pkg::S_BLK_M1:   ctl.hop = cbf_pkg::OP_SCR_MUL1;
      cbf_pkg::S_BLK_M2:   ctl.hop = cbf_pkg::OP_SCR_MUL2;
      cbf_pkg::S_BLK_XOR:  ctl.hop = cbf_pkg::OP_ABS_XOR;
      cbf_pkg::S_BLK_M5:   ctl.hop = cbf_pkg::OP_ABS_MUL5;
      cbf_pkg::S_TL_M1: begin
        ctl.hop = cbf_pkg::OP_SCR_MUL1;
        ctl.tail_sel = 1'b1;
      end
      cbf_pkg::S_TL_M2:    ctl.hop = cbf_pkg::OP_SCR_MUL2;
      cbf_pkg::S_TL_XOR:   ctl.hop = cbf_pkg::OP_TAIL_XOR;
      cbf_pkg::S_FIN_LEN:  ctl.hop = cbf_pkg::OP_FIN_LEN;
      cbf_pkg::S_FIN_M1:   ctl.hop = cbf_pkg::OP_FIN_MUL1;
      cbf_pkg::S_FIN_M2:   ctl.hop = cbf_pkg::OP_FIN_MUL2;
      cbf_pkg::S_FIN_LAST: begin
        ctl.hop = cbf_pkg::OP_FIN_LAST;
        ctl.mod_start = 1'b1;
        ctl.key_clear = 1'b1;
      end
      cbf_pkg::S_MOD:      ctl.rd_a = sts.mod_done;
      cbf_pkg::S_RD_A: begin
        ctl.rd_b = 1'b1;
        ctl.cap_a = 1'b1;
      end
      cbf_pkg::S_RD_B:     ctl.cap_b = 1'b1;
      cbf_pkg::S_WAIT_B:   ctl.hop = cbf_pkg::OP_NOP;
      cbf_pkg::S_WR_A: begin
        ctl.wr_a = 1'b1;
      end
      cbf_pkg::S_RD_B2:    ctl.rd_b = 1'b1;
      cbf_pkg::S_WAIT_B2:  ctl.cap_b = 1'b1;
      cbf_pkg::S_WR_B:     ctl.wr_b = 1'b1;
      cbf_pkg::S_OUT:      ctl.out_load = !out_busy;
      default:             ctl.hop = cbf_pkg::OP_NOP;
    endcase
  end

`ifndef ASSERT_OFF
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == cbf_pkg::S_IDLE) else $error("ready outside idle");
  a_mod_before_read: assert property (@(posedge clk) disable iff (rst)
    state == cbf_pkg::S_RD_A |-> $past(sts.mod_done)) else $error("read before modulo");
  a_write_pair: assert property (@(posedge clk) disable iff (rst)
    ctl.wr_a |-> ##3 ctl.wr_b) else $error("second write missing");
`endif
endmodule

/* hdl/cbf_datapath.sv */
module cbf_datapath #(
  parameter int TABLE_DEPTH = 1024,
  parameter int COUNT_BITS  = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               acc,
  input  logic [1:0]                         in_cmd,
  input  logic [7:0]                         in_byte,
  input  logic                               in_bvalid,
  input  logic                               in_last,
  input  logic [cbf_pkg::SIZE_BITS-1:0]      table_size,
  input  logic [31:0]                        seed_a,
  input  logic [31:0]                        seed_b,
  input  cbf_pkg::ctl_t                      ctl,
  output cbf_pkg::sts_t                      sts,
  output logic                               blk_full,
  output logic                               is_last,
  output logic                               has_tail,
  output logic [1:0]                         cmd,
  output logic                               clearing,
  output logic                               out_busy,
  input  logic                               out_ready,
  output logic [15:0]                        answer,
  output logic [1:0]                         op_done
);
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int SW = AW + 1;
  localparam logic [COUNT_BITS-1:0] CMAX = '1;

  logic [31:0] ha, hb, ka, kb;
  logic [23:0] tail;
  logic [31:0] klen;
  logic [31:0] block;
  logic [SW-1:0] mod;
  logic [AW-1:0] idx_a, idx_b, addr;
  logic [COUNT_BITS-1:0] ca, cb, rdata, wdata;
  logic [AW-1:0] clr_addr;
  logic we;
  logic [15:0] ans;

  // Divider: restoring remainder, one bit per cycle, both hashes in parallel.
  logic [5:0]    mcnt;
  logic          mbusy;
  logic [31:0]   qa, qb;
  logic [SW:0]   ra, rb, ta, tb;

  assign blk_full = acc && in_bvalid && (klen[1:0] == 2'd3);
  // Leftover bytes counted after the byte of the item being taken.
  assign has_tail = (klen[1:0] + 2'(acc && in_bvalid)) != 2'd0;
  assign sts.mod_done = !mbusy && (mcnt == 6'd32);
  assign block = {in_byte, tail};

  always_comb begin
    if (table_size == '0) begin
      mod = SW'(1);
    end else if (32'(table_size) > 32'(TABLE_DEPTH)) begin
      mod = SW'(TABLE_DEPTH);
    end else begin
      mod = SW'(table_size);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      klen <= '0;
      tail <= '0;
      is_last <= 1'b0;
    end else if (acc) begin
      is_last <= in_last;
      if (in_last) cmd <= in_cmd;
      if (in_bvalid) begin
        klen <= klen + 32'd1;
        unique case (klen[1:0])
          2'd0: tail[7:0] <= in_byte;
          2'd1: tail[15:8] <= in_byte;
          2'd2: tail[23:16] <= in_byte;
          default: tail <= '0;
        endcase
      end
    end else if (ctl.key_clear) begin
      klen <= '0;
      tail <= '0;
      is_last <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && in_bvalid && klen == '0) begin
      ha <= seed_a;
      hb <= seed_b;
    end
    if (blk_full) begin
      ka <= block;
      kb <= block;
    end
    unique case (ctl.hop)
      cbf_pkg::OP_LOAD_SEED: if (klen == '0 && !in_bvalid) begin
        ha <= seed_a;
        hb <= seed_b;
      end
      cbf_pkg::OP_SCR_MUL1: begin
        if (ctl.tail_sel) begin
          ka <= cbf_pkg::rotl({8'd0, tail} * cbf_pkg::MIX_C1, 15);
          kb <= cbf_pkg::rotl({8'd0, tail} * cbf_pkg::MIX_C1, 15);
        end else begin
          ka <= cbf_pkg::rotl(ka * cbf_pkg::MIX_C1, 15);
          kb <= ka;
        end
      end
      cbf_pkg::OP_SCR_MUL2: begin
        ka <= ka * cbf_pkg::MIX_C2;
        kb <= ka * cbf_pkg::MIX_C2;
      end
      cbf_pkg::OP_ABS_XOR: begin
        ha <= cbf_pkg::rotl(ha ^ ka, 13);
        hb <= cbf_pkg::rotl(hb ^ kb, 13);
      end
      cbf_pkg::OP_ABS_MUL5: begin
        ha <= ha * 32'd5 + cbf_pkg::MIX_N;
        hb <= hb * 32'd5 + cbf_pkg::MIX_N;
      end
      cbf_pkg::OP_TAIL_XOR: begin
        ha <= ha ^ ka;
        hb <= hb ^ kb;
      end
      cbf_pkg::OP_FIN_LEN: begin
        ha <= (ha ^ klen) ^ ((ha ^ klen) >> 16);
        hb <= (hb ^ klen) ^ ((hb ^ klen) >> 16);
      end
      cbf_pkg::OP_FIN_MUL1: begin
        ha <= (ha * cbf_pkg::FMIX_1) ^ ((ha * cbf_pkg::FMIX_1) >> 13);
        hb <= (hb * cbf_pkg::FMIX_1) ^ ((hb * cbf_pkg::FMIX_1) >> 13);
      end
      cbf_pkg::OP_FIN_MUL2: begin
        ha <= ha * cbf_pkg::FMIX_2;
        hb <= hb * cbf_pkg::FMIX_2;
      end
      cbf_pkg::OP_FIN_LAST: begin
        ha <= ha ^ (ha >> 16);
        hb <= hb ^ (hb >> 16);
      end
      default: begin
      end
    endcase
  end

  assign ta = {ra[SW-1:0], qa[31]};
  assign tb = {rb[SW-1:0], qb[31]};

  always_ff @(posedge clk) begin
    if (rst) begin
      mbusy <= 1'b0;
      mcnt <= '0;
    end else if (ctl.mod_start) begin
      mbusy <= 1'b1;
      mcnt <= '0;
    end else if (mbusy) begin
      mcnt <= mcnt + 6'd1;
      if (mcnt == 6'd31) mbusy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.mod_start) begin
      ra <= '0;
      rb <= '0;
      qa <= ha ^ (ha >> 16);
      qb <= hb ^ (hb >> 16);
    end else if (mbusy) begin
      qa <= qa << 1;
      qb <= qb << 1;
      ra <= (ta >= {1'b0, mod}) ? ta - {1'b0, mod} : ta;
      rb <= (tb >= {1'b0, mod}) ? tb - {1'b0, mod} : tb;
    end
    if (ctl.rd_a) begin
      idx_a <= ra[AW-1:0];
      idx_b <= rb[AW-1:0];
    end
  end

  // Clearing sweep after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + AW'(1);
      if (clr_addr == AW'(TABLE_DEPTH - 1)) clearing <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.cap_a) ca <= rdata;
    if (ctl.cap_b) cb <= rdata;
  end

  always_comb begin
    addr = idx_a;
    if (ctl.rd_b) addr = idx_b;
    else if (ctl.rd_a) addr = ra[AW-1:0];
  end

  // Second pass re-reads b so a coincident index sees the first update.
  logic [COUNT_BITS-1:0] lo, cur, upd;
  logic [COUNT_BITS-1:0] lo_r;
  logic do_rm;
  assign cur = ctl.wr_a ? ca : cb;
  assign lo = (ca < cb) ? ca : cb;
  assign do_rm = lo_r != '0;

  always_ff @(posedge clk) begin
    if (ctl.wr_a) lo_r <= lo;
  end

  always_comb begin
    upd = cur;
    unique case (cmd)
      cbf_pkg::CMD_ADD:    if (cur != CMAX) upd = cur + COUNT_BITS'(1);
      cbf_pkg::CMD_REMOVE: if ((ctl.wr_a ? lo != '0 : do_rm) && cur != '0)
                             upd = cur - COUNT_BITS'(1);
      default:             upd = cur;
    endcase
  end

  assign we = clearing || ctl.wr_a || ctl.wr_b;
  assign wdata = clearing ? '0 : upd;

  cbf_ram #(.WIDTH(COUNT_BITS), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk(clk), .we(we),
    .waddr(clearing ? clr_addr : (ctl.wr_a ? idx_a : idx_b)),
    .wdata(wdata), .raddr(addr), .rdata(rdata)
  );

  always_comb begin
    unique case (cmd)
      cbf_pkg::CMD_REMOVE: ans = do_rm ? 16'd1 : 16'd0;
      cbf_pkg::CMD_CHECK:
        ans = (32'(lo_r) > 32'hFFFF) ? 16'hFFFF : 16'(lo_r);
      default: ans = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_busy <= 1'b0;
    end else if (ctl.out_load) begin
      out_busy <= 1'b1;
    end else if (out_ready) begin
      out_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      answer <= ans;
      op_done <= cmd;
    end
  end

`ifndef ASSERT_OFF
  a_no_op_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !acc) else $error("item during clear");
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    ctl.wr_a |-> (SW'(idx_a) < mod)) else $error("index out of range");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_busy && !out_ready |=> $stable(answer)) else $error("result changed");
`endif
endmodule

/* hdl/counting_bloom_filter_top.sv */
// channel | dir | payload
// in      | in  | cmd[1:0], key_byte[7:0], byte_valid, key_last
// out     | out | answer[15:0], op_done[1:0]
// Every 4th byte of a key adds a block mix: scramble, xor-rotate and multiply-add.
// The last item adds a tail mix when bytes are left over, then finalization; unless
// its command is CMD_NONE, bit-serial modulo, counter read-modify-write and loading
// of the result follow. After reset a pass clears all TABLE_DEPTH counters; no item
// is taken meanwhile. A waiting result holds back the next result, and new items
// once that one is ready; the next key still streams in until then.
module counting_bloom_filter_top #(
  parameter int TABLE_DEPTH = 1024,
  parameter int COUNT_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst,
  cbf_stream_if.sink  in_ch,
  cbf_stream_if.source out_ch,
  input  logic        cfg_we,
  input  logic [cbf_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [cbf_pkg::CFG_DATA_BITS-1:0] cfg_data
);
  logic [cbf_pkg::SIZE_BITS-1:0] table_size;
  logic [31:0] seed_a, seed_b;
  cbf_pkg::ctl_t ctl;
  cbf_pkg::sts_t sts;
  logic blk_full, is_last, has_tail, clearing, out_busy, acc;
  logic [1:0] cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= cbf_pkg::SIZE_BITS'(1024);
      seed_a <= 32'd100;
      seed_b <= 32'd200;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cbf_pkg::REG_TABLE_SIZE: table_size <= cfg_data[cbf_pkg::SIZE_BITS-1:0];
        cbf_pkg::REG_SEED_A:     seed_a <= cfg_data;
        cbf_pkg::REG_SEED_B:     seed_b <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign acc = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_busy;

  cbf_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .blk_full(blk_full), .is_last(is_last || (acc && in_ch.data[0])),
    .has_tail(has_tail), .cmd(cmd), .clearing(clearing),
    .out_busy(out_busy), .sts(sts), .ctl(ctl)
  );

  cbf_datapath #(.TABLE_DEPTH(TABLE_DEPTH), .COUNT_BITS(COUNT_BITS)) u_dp (
    .clk(clk), .rst(rst), .acc(acc),
    .in_cmd(in_ch.data[11:10]), .in_byte(in_ch.data[9:2]),
    .in_bvalid(in_ch.data[1]), .in_last(in_ch.data[0]),
    .table_size(table_size), .seed_a(seed_a), .seed_b(seed_b),
    .ctl(ctl), .sts(sts), .blk_full(blk_full), .is_last(is_last),
    .has_tail(has_tail), .cmd(cmd), .clearing(clearing), .out_busy(out_busy),
    .out_ready(out_ch.ready), .answer(out_ch.data[17:2]), .op_done(out_ch.data[1:0])
  );
endmodule

/* tb/sv/tb_counting_bloom_filter_top.sv */
module tb_counting_bloom_filter_top;

  localparam int DEPTH = 1024;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 80;

  typedef struct packed {
    logic [15:0]   answer;
    cbf_pkg::cmd_t op;
  } bloom_res_t;

  typedef struct {
    cbf_pkg::cmd_t cmd;
    logic [7:0]    kb;
    logic          bv;
    logic          kl;
    bit            fixed;
    logic [15:0]   ans;
  } step_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [cbf_pkg::CFG_IDX_BITS-1:0] cfg_index;
  logic [cbf_pkg::CFG_DATA_BITS-1:0] cfg_data;

  cbf_stream_if #(.W(12)) in_ch ();
  cbf_stream_if #(.W(18)) out_ch ();

  counting_bloom_filter_top #(.TABLE_DEPTH(DEPTH), .COUNT_BITS(16)) u_dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // shadow of the filter
  logic [15:0] counts [DEPTH];
  logic [31:0] size_reg, seed_a_reg, seed_b_reg;
  logic [31:0] hash_a, hash_b, tail_acc, key_len;

  bloom_res_t expected_q[$];
  int fails;
  int cycles;
  int gap_pct;
  int stall_pct;

  function automatic logic [31:0] rol32(logic [31:0] x, int r);
    return (x << r) | (x >> (32 - r));
  endfunction

  function automatic logic [31:0] scramble_word(logic [31:0] k);
    logic [31:0] t;
    t = k * cbf_pkg::MIX_C1;
    t = rol32(t, 15);
    return t * cbf_pkg::MIX_C2;
  endfunction

  function automatic logic [31:0] absorb_word(logic [31:0] h, logic [31:0] blk);
    logic [31:0] t;
    t = rol32(h ^ scramble_word(blk), 13);
    return t * 32'd5 + cbf_pkg::MIX_N;
  endfunction

  function automatic logic [31:0] finish_word(logic [31:0] h, logic [31:0] tl,
                                              logic [31:0] len);
    logic [31:0] t;
    t = h;
    if (len[1:0] != 2'd0) t = t ^ scramble_word(tl);
    t = t ^ len;
    t = t ^ (t >> 16);
    t = t * cbf_pkg::FMIX_1;
    t = t ^ (t >> 13);
    t = t * cbf_pkg::FMIX_2;
    t = t ^ (t >> 16);
    return t;
  endfunction

  task automatic key_restart();
    hash_a = seed_a_reg;
    hash_b = seed_b_reg;
    tail_acc = '0;
    key_len = '0;
  endtask

  task automatic bloom_apply(input cbf_pkg::cmd_t cmd, input logic [7:0] kb,
                             input logic bv, input logic kl, output bit hit,
                             output bloom_res_t r);
    logic [31:0] fa, fb, modulus, sa, sb;
    logic [15:0] ca, cb, lo;
    hit = 0;
    r = '0;
    if (bv) begin
      if (key_len == 0) begin
        hash_a = seed_a_reg;
        hash_b = seed_b_reg;
      end
      if (key_len[1:0] == 2'd3) begin
        hash_a = absorb_word(hash_a, tail_acc | {kb, 24'h0});
        hash_b = absorb_word(hash_b, tail_acc | {kb, 24'h0});
        tail_acc = '0;
      end else begin
        tail_acc = tail_acc | (32'(kb) << (8 * key_len[1:0]));
      end
      key_len = key_len + 1;
    end
    if (!kl) return;
    if (key_len == 0) begin
      hash_a = seed_a_reg;
      hash_b = seed_b_reg;
    end
    fa = finish_word(hash_a, tail_acc, key_len);
    fb = finish_word(hash_b, tail_acc, key_len);
    key_restart();
    if (cmd == cbf_pkg::CMD_NONE) return;
    modulus = (size_reg == 0) ? 1 : (size_reg > DEPTH) ? DEPTH : size_reg;
    sa = fa % modulus;
    sb = fb % modulus;
    ca = counts[sa];
    cb = counts[sb];
    lo = (ca < cb) ? ca : cb;
    r.op = cmd;
    case (cmd)
      cbf_pkg::CMD_ADD: begin
        if (counts[sa] != 16'hffff) counts[sa]++;
        if (counts[sb] != 16'hffff) counts[sb]++;
        r.answer = 0;
      end
      cbf_pkg::CMD_REMOVE: begin
        if (lo == 0) begin
          r.answer = 0;
        end else begin
          if (counts[sa] != 0) counts[sa]--;
          if (counts[sb] != 0) counts[sb]--;
          r.answer = 1;
        end
      end
      default: r.answer = lo;
    endcase
    hit = 1;
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    fails++;
  endtask

  // fixed_ans >= 0 replaces the predicted answer with a hand-written one
  task automatic send_item(input cbf_pkg::cmd_t cmd, input logic [7:0] kb,
                           input logic bv, input logic kl, input int fixed_ans);
    bit hit;
    bloom_res_t r;
    if ($urandom_range(0, 99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= {cmd, kb, bv, kl};
    do @(posedge clk); while (!in_ch.ready);
    bloom_apply(cmd, kb, bv, kl, hit, r);
    if (hit) begin
      if (fixed_ans >= 0) r.answer = fixed_ans[15:0];
      expected_q.push_back(r);
    end
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cbf_pkg::reg_idx_t idx, input logic [31:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    case (idx)
      cbf_pkg::REG_TABLE_SIZE: size_reg = value & 32'h7ff;
      cbf_pkg::REG_SEED_A: seed_a_reg = value;
      default: seed_b_reg = value;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic cbf_pkg::cmd_t pick_cmd();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) return cbf_pkg::CMD_ADD;
    if (p < 75) return cbf_pkg::CMD_CHECK;
    if (p < 95) return cbf_pkg::CMD_REMOVE;
    return cbf_pkg::CMD_NONE;
  endfunction

  task automatic random_phase(input int n_items);
    logic [7:0] pool [12][10];
    int pool_len [12];
    int sent, k, i;
    for (k = 0; k < 12; k++) begin
      pool_len[k] = $urandom_range(0, 9);
      for (i = 0; i < 10; i++) pool[k][i] = $urandom_range(0, 255);
    end
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 99) < 85) begin
        k = $urandom_range(0, 11);
        for (i = 0; i < pool_len[k]; i++) begin
          if ($urandom_range(0, 99) < 8) begin
            send_item(cbf_pkg::CMD_ADD, 8'($urandom), 1'b0, 1'b0, -1);
            sent++;
          end
          if (i == pool_len[k] - 1 && $urandom_range(0, 3) != 0) begin
            send_item(pick_cmd(), pool[k][i], 1'b1, 1'b1, -1);
            sent++;
            break;
          end
          send_item(cbf_pkg::cmd_t'($urandom_range(0, 3)), pool[k][i], 1'b1, 1'b0, -1);
          sent++;
        end
        if (i == pool_len[k]) begin
          send_item(pick_cmd(), 8'($urandom), 1'b0, 1'b1, -1);
          sent++;
        end
      end else begin
        send_item(cbf_pkg::cmd_t'($urandom_range(0, 3)), 8'($urandom), 1'($urandom),
                  1'($urandom), -1);
        sent++;
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    bloom_res_t got, want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result, answer", got.answer, -1);
      end else begin
        want = expected_q.pop_front();
        if (got.answer !== want.answer) report_mismatch("answer", got.answer, want.answer);
        if (got.op !== want.op) report_mismatch("op_done", got.op, want.op);
      end
    end
    out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  initial begin
    step_t script [26] = '{
      '{cbf_pkg::CMD_CHECK,  8'h00, 1'b0, 1'b1, 1'b1, 16'd0},
      '{cbf_pkg::CMD_REMOVE, 8'h00, 1'b0, 1'b1, 1'b1, 16'd0},
      '{cbf_pkg::CMD_ADD,    8'h00, 1'b0, 1'b1, 1'b1, 16'd0},
      '{cbf_pkg::CMD_CHECK,  8'h00, 1'b0, 1'b1, 1'b0, 16'd0},
      '{cbf_pkg::CMD_REMOVE, 8'h00, 1'b0, 1'b1, 1'b0, 16'd0},
      '{cbf_pkg::CMD_ADD,    8'h00, 1'b1, 1'b0, 1'b0, 16'd0},
      '{cbf_pkg::CMD_ADD,    8'hff, 1'b1, 1'b0, 1'b0, 16'd0},
      '{cbf_pkg::CMD_ADD,    8'h00, 1'b0, 1'b0, 1'b0, 16'd0},
      '{cbf_pkg::CMD_ADD,    8'h5a, 1'b1, 1'b0, 1'b0, 16'd0},
      '{cbf_pkg::CMD_ADD,    8'ha5, 1'b1, 1'b1, 1'b1, 16'd0},
      '{cbf_pkg::CMD_CHECK,  8'h00, 1'b1, 1'b0, 1'b0, 16'd0},
      '{cbf_pkg::CMD_CHECK,  8'hff, 1'b1, 1'b0, 1'b0, 16'd0},
      '{cbf_pkg::CMD_CHECK,  8'h00, 1'b0, 1'b0, 1'b0, 16'd0},
      '{cbf_pkg::CMD_CHECK,  8'h5a, 1'b1, 1'b0, 1'b0, 16'd0},
      '{cbf_pkg::CMD_CHECK,  8'ha5, 1'b1, 1'b1, 1'b0, 16'd0},
      '{cbf_pkg::CMD_ADD,    8'h11, 1'b1, 1'b0, 1'b0, 16'd0},
      '{cbf_pkg::CMD_ADD,    8'h22, 1'b1, 1'b0, 1'b0, 16'd0},
      '{cbf_pkg::CMD_NONE,   8'h33, 1'b1, 1'b1, 1'b0, 16'd0},
      '{cbf_pkg::CMD_ADD,    8'h11, 1'b1, 1'b0, 1'b0, 16'd0},
      '{cbf_pkg::CMD_ADD,    8'h22, 1'b1, 1'b0, 1'b0, 16'd0},
      '{cbf_pkg::CMD_ADD,    8'h33, 1'b1, 1'b0, 1'b0, 16'd0},
      '{cbf_pkg::CMD_ADD,    8'h44, 1'b1, 1'b0, 1'b0, 16'd0},
      '{cbf_pkg::CMD_ADD,    8'h55, 1'b1, 1'b0, 1'b0, 16'd0},
      '{cbf_pkg::CMD_ADD,    8'h00, 1'b0, 1'b1, 1'b1, 16'd0},
      '{cbf_pkg::CMD_REMOVE, 8'h7f, 1'b1, 1'b1, 1'b0, 16'd0},
      '{cbf_pkg::CMD_CHECK,  8'h80, 1'b1, 1'b1, 1'b0, 16'd0}
    };
    logic [31:0] sizes [6] = '{32'd1024, 32'd1, 32'd0, 32'd7, 32'd2047, 32'd3};
    int ph;
    fails = 0;
    cycles = 0;
    gap_pct = 0;
    stall_pct = 0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    size_reg = 32'd1024;
    seed_a_reg = 32'd100;
    seed_b_reg = 32'd200;
    for (int i = 0; i < DEPTH; i++) counts[i] = '0;
    key_restart();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (script[i])
      send_item(script[i].cmd, script[i].kb, script[i].bv, script[i].kl,
                script[i].fixed ? int'(script[i].ans) : -1);

    for (ph = 0; ph < 6; ph++) begin
      settle();
      gap_pct = (ph < 2) ? 11 : (ph < 4) ? 67 : 0;
      stall_pct = (ph < 2) ? 67 : (ph < 4) ? 11 : 0;
      write_reg(cbf_pkg::REG_TABLE_SIZE, sizes[ph]);
      case (ph)
        0: begin
          write_reg(cbf_pkg::REG_SEED_A, 32'd100);
          write_reg(cbf_pkg::REG_SEED_B, 32'd200);
        end
        1: begin
          write_reg(cbf_pkg::REG_SEED_A, 32'h0);
          write_reg(cbf_pkg::REG_SEED_B, 32'hffffffff);
        end
        2: begin
          write_reg(cbf_pkg::REG_SEED_A, 32'hffffffff);
          write_reg(cbf_pkg::REG_SEED_B, 32'h0);
        end
        default: begin
          write_reg(cbf_pkg::REG_SEED_A, $urandom);
          write_reg(cbf_pkg::REG_SEED_B, $urandom);
        end
      endcase
      random_phase(140);
    end

    settle();
    if (fails == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
